FILE: sv/pitd_pkg.sv
// ----------------------------------------------------------------------------
// pitd_pkg: shared types and constants for the padded integer digit formatter
// Holds the controller states, the command and status bundles between the
// controller and the datapath, the character codes and the power table.
// ----------------------------------------------------------------------------
package pitd_pkg;

   localparam int MAX_DIGITS_DEFAULT = 10;
   localparam int HEX_DIGIT_LIMIT    = 8;

   localparam int NUMBER_WIDTH = 32;
   localparam int COUNT_WIDTH  = 4;
   localparam int MODE_WIDTH   = 2;
   localparam int DIGIT_WIDTH  = 4;
   localparam int CKIND_WIDTH  = 2;
   localparam int SHIFT_WIDTH  = 5;

   // Packed widths of the stream buses.
   localparam int REQ_TDATA_WIDTH = 40;
   localparam int RSP_TDATA_WIDTH = 8;

   localparam logic [CKIND_WIDTH-1:0] CK_DIGIT    = 2'd0;
   localparam logic [CKIND_WIDTH-1:0] CK_SPACE    = 2'd1;
   localparam logic [CKIND_WIDTH-1:0] CK_OVERFLOW = 2'd2;

   localparam logic [MODE_WIDTH-1:0] ALIGN_LEFT  = 2'd0;
   localparam logic [MODE_WIDTH-1:0] ALIGN_RIGHT = 2'd1;
   localparam logic [MODE_WIDTH-1:0] ALIGN_ZEROS = 2'd2;

   localparam logic [SHIFT_WIDTH-1:0] LEAD_SHIFT  = 5'd31;
   localparam logic [SHIFT_WIDTH-1:0] DIGIT_SHIFT = 5'd3;

   localparam logic [DIGIT_WIDTH-1:0] DEC_RADIX = 4'd10;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DECIDE,
      ST_OUTPUT
   } ctl_state_type;

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_DIGITS,
      PH_SPACES
   } phase_type;

   typedef struct packed {
      logic load;
      logic step;
      logic decide;
      logic advance;
   } dp_cmd_type;

   typedef struct packed {
      logic shift_zero;
      logic emit;
      logic at_ones;
   } dp_status_type;

   // Radix raised to a position, for positions 0 to 9 in decimal and 0 to 7 in hexadecimal.
   function automatic logic [NUMBER_WIDTH-1:0] radix_power(input logic hex,
                                                         input logic [COUNT_WIDTH-1:0] pos);
      logic [NUMBER_WIDTH-1:0] p;
      begin
         p = 32'd1;
         if (hex) begin
            case (pos)
               4'd0:    p = 32'h0000_0001;
               4'd1:    p = 32'h0000_0010;
               4'd2:    p = 32'h0000_0100;
               4'd3:    p = 32'h0000_1000;
               4'd4:    p = 32'h0001_0000;
               4'd5:    p = 32'h0010_0000;
               4'd6:    p = 32'h0100_0000;
               4'd7:    p = 32'h1000_0000;
               default: p = 32'h1000_0000;
            endcase
         end else begin
            case (pos)
               4'd0:    p = 32'd1;
               4'd1:    p = 32'd10;
               4'd2:    p = 32'd100;
               4'd3:    p = 32'd1000;
               4'd4:    p = 32'd10000;
               4'd5:    p = 32'd100000;
               4'd6:    p = 32'd1000000;
               4'd7:    p = 32'd10000000;
               4'd8:    p = 32'd100000000;
               4'd9:    p = 32'd1000000000;
               default: p = 32'd1000000000;
            endcase
         end
         return p;
      end
   endfunction

endpackage

FILE: sv/pitd_ctl.sv
// ----------------------------------------------------------------------------
// pitd_ctl: sequencer for the padded integer digit formatter
// Accepts one number, runs the compare-subtract steps for each position,
// decides whether a character is written and hands it to the result bus.
// ----------------------------------------------------------------------------
module pitd_ctl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output pitd_pkg::dp_cmd_type    cmd,
   input  pitd_pkg::dp_status_type status
);
   import pitd_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (status.shift_zero) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (status.emit) begin
               state_in = ST_OUTPUT;
            end else begin
               // A suppressed leading zero: go straight to the next position.
               cmd.advance = 1'b1;
               state_in    = ST_DIVIDE;
            end
         end
         ST_OUTPUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (status.at_ones) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_DIVIDE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/pitd_dp.sv
// ----------------------------------------------------------------------------
// pitd_dp: datapath for the padded integer digit formatter
// Keeps the magnitude remainder, the position, the shift step and the
// quotient bits, and forms the character for each position.
// ----------------------------------------------------------------------------
module pitd_dp #(
   parameter int MAX_DIGITS = pitd_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic [pitd_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   input  logic                                  req_tuser,
   output logic [pitd_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   output logic [pitd_pkg::CKIND_WIDTH-1:0]      rsp_tuser,
   output logic                                  rsp_tlast,
   input  pitd_pkg::dp_cmd_type                  cmd,
   output pitd_pkg::dp_status_type               status
);
   import pitd_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] DEC_LIMIT = COUNT_WIDTH'(MAX_DIGITS);
   localparam logic [COUNT_WIDTH-1:0] HEX_LIMIT =
      COUNT_WIDTH'((MAX_DIGITS > HEX_DIGIT_LIMIT) ? HEX_DIGIT_LIMIT : MAX_DIGITS);

   logic [NUMBER_WIDTH-1:0] rem_ff,  rem_in;
   logic                    neg_ff,  neg_in;
   logic                    hex_ff,  hex_in;
   logic [COUNT_WIDTH-1:0]  pos_ff,  pos_in;
   logic [SHIFT_WIDTH-1:0]  shift_ff, shift_in;
   logic [DIGIT_WIDTH-1:0]  qlo_ff,  qlo_in;
   logic                    qbig_ff, qbig_in;
   phase_type               phase_ff, phase_in;
   logic [CKIND_WIDTH-1:0]  ck_ff,   ck_in;
   logic [DIGIT_WIDTH-1:0]  dv_ff,   dv_in;
   logic                    last_ff, last_in;

   logic [NUMBER_WIDTH-1:0]   number;
   logic [MODE_WIDTH-1:0]     align_mode;
   logic [COUNT_WIDTH-1:0]    digit_count;
   logic [COUNT_WIDTH-1:0]    limit;
   logic [COUNT_WIDTH-1:0]    count_clamped;
   logic [NUMBER_WIDTH-1:0]   power;
   logic [2*NUMBER_WIDTH-1:0] shifted;
   logic                      sub_ok;
   logic                      q_nonzero;
   logic                      q_overflow;
   logic                      write_char;

   assign number      = req_tdata[NUMBER_WIDTH-1:0];
   assign align_mode  = req_tdata[NUMBER_WIDTH+MODE_WIDTH-1:NUMBER_WIDTH];
   assign digit_count = req_tdata[NUMBER_WIDTH+MODE_WIDTH+COUNT_WIDTH-1:
                                  NUMBER_WIDTH+MODE_WIDTH];

   always_comb begin
      limit         = req_tuser ? HEX_LIMIT : DEC_LIMIT;
      count_clamped = digit_count;
      if (digit_count == '0) begin
         count_clamped = COUNT_WIDTH'(1);
      end
      if (count_clamped > limit) begin
         count_clamped = limit;
      end
   end

   // Power of the radix shifted by the current step; a shift past 32 bits
   // can never fit under the remainder.
   assign power   = radix_power(hex_ff, pos_ff);
   assign shifted = {{NUMBER_WIDTH{1'b0}}, power} << shift_ff;
   assign sub_ok  = (shifted[2*NUMBER_WIDTH-1:NUMBER_WIDTH] == '0) &&
                    (rem_ff >= shifted[NUMBER_WIDTH-1:0]);

   assign q_nonzero  = qbig_ff || (qlo_ff != '0);
   assign q_overflow = qbig_ff || (!hex_ff && (qlo_ff >= DEC_RADIX)) ||
                       (neg_ff && q_nonzero);
   assign write_char = (phase_ff == PH_DIGITS) || q_nonzero || (pos_ff == '0);

   assign status.shift_zero = (shift_ff == '0);
   assign status.emit       = write_char || (phase_ff == PH_SPACES);
   assign status.at_ones    = (pos_ff == '0);

   always_comb begin
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      hex_in   = hex_ff;
      pos_in   = pos_ff;
      shift_in = shift_ff;
      qlo_in   = qlo_ff;
      qbig_in  = qbig_ff;
      phase_in = phase_ff;
      ck_in    = ck_ff;
      dv_in    = dv_ff;
      last_in  = last_ff;
      if (cmd.load) begin
         neg_in   = number[NUMBER_WIDTH-1];
         rem_in   = number[NUMBER_WIDTH-1] ? (~number + 32'd1) : number;
         hex_in   = req_tuser;
         pos_in   = count_clamped - COUNT_WIDTH'(1);
         shift_in = LEAD_SHIFT;
         qlo_in   = '0;
         qbig_in  = 1'b0;
         case (align_mode)
            ALIGN_RIGHT: phase_in = PH_SPACES;
            ALIGN_ZEROS: phase_in = PH_DIGITS;
            default:     phase_in = PH_WAIT;
         endcase
      end
      if (cmd.step) begin
         if (sub_ok) begin
            rem_in = rem_ff - shifted[NUMBER_WIDTH-1:0];
            if (shift_ff > SHIFT_WIDTH'(DIGIT_SHIFT)) begin
               qbig_in = 1'b1;
            end else begin
               qlo_in[shift_ff[1:0]] = 1'b1;
            end
         end
         if (shift_ff != '0) begin
            shift_in = shift_ff - SHIFT_WIDTH'(1);
         end
      end
      if (cmd.decide) begin
         last_in = (pos_ff == '0);
         if (write_char) begin
            phase_in = PH_DIGITS;
            ck_in    = q_overflow ? CK_OVERFLOW : CK_DIGIT;
            dv_in    = q_overflow ? '0 : qlo_ff;
         end else begin
            ck_in = CK_SPACE;
            dv_in = '0;
         end
      end
      if (cmd.advance) begin
         // After the leading position the quotient stays below the radix.
         pos_in   = pos_ff - COUNT_WIDTH'(1);
         shift_in = DIGIT_SHIFT;
         qlo_in   = '0;
         qbig_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
      hex_ff   <= hex_in;
      pos_ff   <= pos_in;
      shift_ff <= shift_in;
      qlo_ff   <= qlo_in;
      qbig_ff  <= qbig_in;
      phase_ff <= phase_in;
      ck_ff    <= ck_in;
      dv_ff    <= dv_in;
      last_ff  <= last_in;
   end

   assign rsp_tdata = {{(RSP_TDATA_WIDTH-DIGIT_WIDTH){1'b0}}, dv_ff};
   assign rsp_tuser = ck_ff;
   assign rsp_tlast = last_ff;

endmodule

FILE: sv/padded_int_to_digits.sv
// ----------------------------------------------------------------------------
// padded_int_to_digits: fixed-width signed integer to digit string formatter
// Each beat in carries one number; one beat out per written character.
// Sequence: the leading position runs compare-subtract steps over every shift
// of the power, each later position only over the shifts of one digit; then
// a decide step per position and an output step per written character, held
// while the result bus stalls. One number at a time: the next is taken only
// after the final character of the last; all positions share one compare-subtract unit.
// Reset: synchronous, active high; the sequencer returns to idle.
// ----------------------------------------------------------------------------
module padded_int_to_digits #(
   parameter int MAX_DIGITS = pitd_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // number [31:0], align_mode [33:32], digit_count [37:34], zero fill above
   input  logic [pitd_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   // kind: 0 decimal, 1 hexadecimal
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // digit_value [3:0], zero fill above
   output logic [pitd_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   // char_kind [1:0]
   output logic [pitd_pkg::CKIND_WIDTH-1:0]      rsp_tuser,
   output logic                                  rsp_tlast
);
   import pitd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   pitd_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   pitd_dp #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dp (
      .clock     (clock),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

FILE: sv/pitd_checker.sv
// ----------------------------------------------------------------------------
// pitd_checker: port-level checks for the padded integer digit formatter
// Watches the stream buses and checks the one-number-at-a-time sequencing.
// ----------------------------------------------------------------------------
module pitd_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [pitd_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   input logic [pitd_pkg::CKIND_WIDTH-1:0]      rsp_tuser,
   input logic                                  rsp_tlast
);
   import pitd_pkg::*;

   // A number being walked blocks the input bus.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted again while a number is in progress");

   // The input bus reopens right after the final character is taken.
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("block did not return to idle after the final character");

   // Characters and input acceptance never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready while a character is pending");

   // Only digits carry a value.
   a_value_only_on_digit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != CK_DIGIT)) |-> (rsp_tdata == '0))
      else $error("space or overflow mark carries a digit value");

   // A stalled character holds.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled character changed");

endmodule

bind padded_int_to_digits pitd_checker u_pitd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the padded integer digit formatter
// Feeds numbers with every radix, alignment and field width over the request
// stream, predicts the characters each one must produce and compares every
// response beat in order, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pitd_pkg::*;

   localparam logic [MODE_WIDTH-1:0] ALIGN_UNUSED = 2'd3;
   localparam logic KIND_DEC = 1'b0;
   localparam logic KIND_HEX = 1'b1;
   localparam int   IDLE_LIMIT = 4000;
   localparam int   DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [CKIND_WIDTH-1:0] ckind;
      logic [DIGIT_WIDTH-1:0] digit;
      logic                   last;
   } char_beat_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   logic                       req_tuser = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic [CKIND_WIDTH-1:0]     rsp_tuser;
   logic                       rsp_tlast;

   char_beat_type expected_chars[$];
   int            error_count = 0;
   int            req_gap_max = 6;
   int            rsp_stall_max = 6;

   padded_int_to_digits u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Walks the positions from the highest power down and queues the
   // characters the formatter must write for one number.
   task automatic predict_chars(input logic signed [NUMBER_WIDTH-1:0] number,
                                input logic hex,
                                input logic [MODE_WIDTH-1:0] align,
                                input logic [COUNT_WIDTH-1:0] width);
      longint        value;
      longint        power;
      longint        quot;
      longint        radix;
      int            lim;
      int            cnt;
      int            pos;
      phase_type     phase;
      char_beat_type beat;
      char_beat_type line[$];
      value = longint'(number);
      radix = hex ? 16 : 10;
      lim = MAX_DIGITS_DEFAULT;
      if (hex && lim > HEX_DIGIT_LIMIT) begin
         lim = HEX_DIGIT_LIMIT;
      end
      cnt = int'(width);
      if (cnt < 1) begin
         cnt = 1;
      end
      if (cnt > lim) begin
         cnt = lim;
      end
      phase = PH_WAIT;
      if (align == ALIGN_RIGHT) begin
         phase = PH_SPACES;
      end
      if (align == ALIGN_ZEROS) begin
         phase = PH_DIGITS;
      end
      for (pos = cnt - 1; pos >= 0; pos--) begin
         power = 1;
         repeat (pos) power = power * radix;
         quot = value / power;
         if (phase == PH_DIGITS || quot != 0 || pos == 0) begin
            phase = PH_DIGITS;
            // A negative or oversized quotient is the overflow mark; the
            // remainder still carries on to the next position.
            if (quot >= 0 && quot < radix) begin
               beat = '{CK_DIGIT, quot[3:0], 1'b0};
            end else begin
               beat = '{CK_OVERFLOW, 4'd0, 1'b0};
            end
            line.push_back(beat);
         end else if (phase == PH_SPACES) begin
            line.push_back('{CK_SPACE, 4'd0, 1'b0});
         end
         value = value % power;
      end
      beat = line.pop_back();
      beat.last = 1'b1;
      line.push_back(beat);
      foreach (line[i]) expected_chars.push_back(line[i]);
   endtask

   // Drives one number on the request stream and waits for its beat.
   task automatic send_number(input logic [NUMBER_WIDTH-1:0] number,
                              input logic hex,
                              input logic [MODE_WIDTH-1:0] align,
                              input logic [COUNT_WIDTH-1:0] width);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, width, align, number};
      req_tuser  <= hex;
      do @(posedge clock); while (!req_tready);
      predict_chars(number, hex, align, width);
      @(negedge clock);
   endtask

   // Mostly values that fit the field, with random leading digits
   // suppressed; the rest are raw words and small negatives.
   function automatic logic [NUMBER_WIDTH-1:0] rand_number(input logic hex,
                                                           input int digits);
      longint span;
      longint mag;
      int     k;
      k = $urandom_range(1, digits);
      span = 1;
      repeat (k) span = span * (hex ? 16 : 10);
      case ($urandom_range(0, 9))
         0, 1: begin
            mag = longint'($urandom);
         end
         2: begin
            mag = -longint'($urandom_range(1, 999));
         end
         default: begin
            mag = longint'($urandom) % span;
         end
      endcase
      return mag[NUMBER_WIDTH-1:0];
   endfunction

   task automatic test_extremes();
      send_number(32'd0,           KIND_DEC, ALIGN_LEFT,  4'd1);
      send_number(32'd0,           KIND_DEC, ALIGN_RIGHT, 4'd10);
      send_number(32'd0,           KIND_HEX, ALIGN_ZEROS, 4'd8);
      send_number(32'hFFFF_FFFF,   KIND_DEC, ALIGN_LEFT,  4'd10);
      send_number(32'hFFFF_FFFF,   KIND_HEX, ALIGN_RIGHT, 4'd8);
      send_number(32'h7FFF_FFFF,   KIND_DEC, ALIGN_LEFT,  4'd10);
      send_number(32'h8000_0000,   KIND_DEC, ALIGN_ZEROS, 4'd10);
      send_number(32'h7FFF_FFFF,   KIND_HEX, ALIGN_ZEROS, 4'd8);
      send_number(32'd1000000000,  KIND_DEC, ALIGN_RIGHT, 4'd10);
      send_number(32'd999999999,   KIND_DEC, ALIGN_ZEROS, 4'd10);
   endtask

   task automatic test_overflow_marks();
      send_number(32'd123456,      KIND_DEC, ALIGN_LEFT,  4'd3);
      send_number(32'd255,         KIND_HEX, ALIGN_RIGHT, 4'd1);
      send_number(-32'sd42,        KIND_DEC, ALIGN_ZEROS, 4'd4);
      send_number(-32'sd42,        KIND_HEX, ALIGN_LEFT,  4'd2);
      send_number(32'hDEAD_BEEF,   KIND_HEX, ALIGN_RIGHT, 4'd8);
   endtask

   task automatic test_width_clamp();
      send_number(32'd7,           KIND_DEC, ALIGN_RIGHT,  4'd0);
      send_number(32'd12345,       KIND_DEC, ALIGN_LEFT,   4'd15);
      send_number(32'h89AB_CDEF,   KIND_HEX, ALIGN_ZEROS,  4'd15);
      send_number(32'h0000_1234,   KIND_HEX, ALIGN_RIGHT,  4'd9);
      send_number(32'd1234567890,  KIND_DEC, ALIGN_ZEROS,  4'd11);
      send_number(32'd305,         KIND_DEC, ALIGN_UNUSED, 4'd5);
      send_number(32'h0000_00F0,   KIND_HEX, ALIGN_UNUSED, 4'd6);
   endtask

   task automatic test_random_formats(input int items);
      logic hex;
      int   digits;
      logic [COUNT_WIDTH-1:0] width;
      repeat (items) begin
         hex = 1'($urandom_range(0, 1));
         digits = $urandom_range(1, hex ? HEX_DIGIT_LIMIT : MAX_DIGITS_DEFAULT);
         width = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'(digits);
         send_number(rand_number(hex, digits), hex, 2'($urandom_range(0, 3)), width);
      end
   endtask

   task automatic test_back_to_back(input int items);
      req_gap_max = 0;
      rsp_stall_max = 0;
      test_random_formats(items);
      req_gap_max = 6;
      rsp_stall_max = 6;
   endtask

   // Response sink: draws a stall per beat, then takes and checks the beat.
   initial begin : rsp_sink
      int            stall;
      char_beat_type want;
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected beat kind %0d data %0h last %0b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_tuser !== want.ckind) begin
               $display("%0t: char_kind expected %0d actual %0d",
                        $time, want.ckind, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata !== {4'd0, want.digit}) begin
               $display("%0t: digit_value expected %0h actual %0h",
                        $time, want.digit, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last expected %0b actual %0b",
                        $time, want.last, rsp_tlast);
               error_count++;
            end
         end
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("FAIL padded_int_to_digits");
      $finish;
   end

   initial begin : main
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_extremes();
      test_overflow_marks();
      test_width_clamp();
      test_random_formats(300);
      test_back_to_back(120);
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("PASS padded_int_to_digits");
      end else begin
         $display("FAIL padded_int_to_digits");
      end
      $finish;
   end

endmodule
